### design/bcc_pkg.sv
// Package: payload types, event codes and register indexes for the button click classifier.
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int TS_W       = 32;
    localparam int WIN_W      = 8;
    localparam int CLICK_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'd1;

    localparam logic [WIN_W-1:0] WINDOW_LEN_RST = 8'd100;
    localparam logic [TS_W-1:0]  TIMEOUT_RST    = 32'd500;

    localparam logic [CLICK_W-1:0] CLICK_MAX = 2'd3;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_SINGLE      = 3'd1,
        EV_DOUBLE      = 3'd2,
        EV_SINGLE_LONG = 3'd3,
        EV_DOUBLE_LONG = 3'd4
    } t_event;

    typedef struct packed {
        logic            sample;
        logic [TS_W-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        t_event event_res;
        logic   held;
    } t_out_item;

endpackage

`default_nettype wire

### design/button_click_classifier.sv
// Top level: debounced button sampler that classifies single, double and long clicks.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in): one raw button sample and a
//   timestamp per transfer. Output channel (o_out_valid / i_out_ready / o_out):
//   exactly one result per input transfer, in order: event code and debounced level.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 window_len, 1 timeout) at the clock edge; write only while idle.
// Pipeline: the input transfer loads the input register, which loads the result
//   register when the result register is empty or taken; o_out_valid rises as the
//   result register loads. Throughput: one item per cycle while the output does not
//   stall; the state update is a single pass of run counters, one 32-bit subtract
//   and the window and timeout compares between the input and result registers.
// Reset (i_rst_n low, synchronous): both stages empty, button released, run
//   history as a full window of zeros, click count and press time zero,
//   window_len 100, timeout 500.
// Stall: while i_out_ready is low the result holds; the input register still
//   takes one more transfer, then o_in_ready drops until the result moves.
`timescale 1ns / 1ps
`default_nettype none

module button_click_classifier #(
    parameter int MAX_WINDOW = 128
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [bcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [bcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  bcc_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output bcc_pkg::t_out_item            o_out
);
    import bcc_pkg::*;

    localparam int RUN_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (RUN_W > WIN_W) ? RUN_W : WIN_W;
    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_WINDOW);
    localparam logic [CMP_W-1:0] WIN_MAX = CMP_W'(MAX_WINDOW);
    localparam logic [CMP_W-1:0] WIN_ONE = CMP_W'(1);

    logic [WIN_W-1:0]   r_window_len;
    logic [TS_W-1:0]    r_timeout;

    logic               r_s1_valid;
    t_in_item           r_s1;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               r_is_held;
    logic [RUN_W-1:0]   r_true_run;
    logic [RUN_W-1:0]   r_false_run;
    logic [CLICK_W-1:0] r_click_count;
    logic [TS_W-1:0]    r_press_time;

    logic               n_is_held;
    logic [RUN_W-1:0]   n_true_run;
    logic [RUN_W-1:0]   n_false_run;
    logic [CLICK_W-1:0] n_click_count;
    logic [TS_W-1:0]    n_press_time;
    t_out_item          n_out;

    logic               out_move;
    logic               s1_fire;
    logic [CMP_W-1:0]   win_ext;
    logic [CMP_W-1:0]   win_eff;
    logic               press;
    logic               release_ok;
    logic [TS_W-1:0]    elapsed;
    logic [CLICK_W-1:0] click_mid;
    logic               timer_fire;
    t_event             ev;

    assign out_move    = !r_out_valid || i_out_ready;
    assign s1_fire     = r_s1_valid && out_move;
    assign o_in_ready  = !r_s1_valid || out_move;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        win_ext = CMP_W'(r_window_len);
        if (win_ext == '0) begin
            win_eff = WIN_ONE;
        end else if (win_ext > WIN_MAX) begin
            win_eff = WIN_MAX;
        end else begin
            win_eff = win_ext;
        end

        if (r_s1.sample) begin
            n_true_run  = (r_true_run < RUN_MAX) ? r_true_run + RUN_W'(1) : r_true_run;
            n_false_run = '0;
        end else begin
            n_false_run = (r_false_run < RUN_MAX) ? r_false_run + RUN_W'(1) : r_false_run;
            n_true_run  = '0;
        end

        press      = !r_is_held && (CMP_W'(n_true_run) >= win_eff);
        release_ok = r_is_held && (CMP_W'(n_false_run) >= win_eff);
        elapsed    = r_s1.timestamp - r_press_time;

        n_press_time = press ? r_s1.timestamp : r_press_time;
        n_is_held    = press ? 1'b1 : (release_ok ? 1'b0 : r_is_held);

        click_mid = r_click_count;
        if (release_ok && (elapsed < r_timeout) && (r_click_count != CLICK_MAX)) begin
            click_mid = r_click_count + CLICK_W'(1);
        end

        // a fresh press restarts the timer at zero elapsed time
        timer_fire = !press && (elapsed > r_timeout);

        ev = EV_NONE;
        if (timer_fire) begin
            if (n_is_held) begin
                if (click_mid == 2'd0) begin
                    ev = EV_SINGLE_LONG;
                end else if (click_mid == 2'd1) begin
                    ev = EV_DOUBLE_LONG;
                end
            end else begin
                if (click_mid == 2'd1) begin
                    ev = EV_SINGLE;
                end else if (click_mid == 2'd2) begin
                    ev = EV_DOUBLE;
                end
            end
        end
        n_click_count = timer_fire ? '0 : click_mid;

        n_out.event_res = ev;
        n_out.held      = n_is_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len  <= WINDOW_LEN_RST;
            r_timeout     <= TIMEOUT_RST;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_is_held     <= 1'b0;
            r_true_run    <= '0;
            r_false_run   <= RUN_MAX;
            r_click_count <= '0;
            r_press_time  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WINDOW_LEN: r_window_len <= i_cfg_data[WIN_W-1:0];
                    CFG_TIMEOUT:    r_timeout    <= i_cfg_data[TS_W-1:0];
                    default:        ;
                endcase
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_move) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                r_is_held     <= n_is_held;
                r_true_run    <= n_true_run;
                r_false_run   <= n_false_run;
                r_click_count <= n_click_count;
                r_press_time  <= n_press_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    a_held_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (o_out.held == r_is_held))
        else $error("result level differs from debounced state");

    a_short_events_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.event_res == EV_SINGLE || o_out.event_res == EV_DOUBLE)
        |-> !o_out.held)
        else $error("click event reported while held");

    a_long_events_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.event_res == EV_SINGLE_LONG ||
                        o_out.event_res == EV_DOUBLE_LONG)
        |-> o_out.held)
        else $error("long event reported while released");

    a_runs_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_true_run != '0) && (r_false_run != '0)))
        else $error("true and false runs both nonzero");

endmodule

`default_nettype wire

### sim/tb_button_click_classifier.sv
// Testbench for button_click_classifier: directed and random samples checked against a predictor.
`timescale 1ns / 1ps

module tb_button_click_classifier;

    import bcc_pkg::*;

    localparam int MAX_WIN = 128;

    class click_scoreboard;
        logic [WIN_W-1:0]   win_len;
        logic [TS_W-1:0]    tmo;
        bit                 held;
        int unsigned        ones_run;
        int unsigned        zeros_run;
        logic [CLICK_W-1:0] clicks;
        logic [TS_W-1:0]    press_ts;
        t_out_item          pending_events[$];
        int                 errors;

        function new();
            win_len   = WINDOW_LEN_RST;
            tmo       = TIMEOUT_RST;
            held      = 1'b0;
            ones_run  = 0;
            zeros_run = MAX_WIN;
            clicks    = '0;
            press_ts  = '0;
            errors    = 0;
        endfunction

        function int unsigned eff_window();
            if (win_len == 0) return 1;
            if (win_len > MAX_WIN) return MAX_WIN;
            return win_len;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WINDOW_LEN: win_len = data[WIN_W-1:0];
                CFG_TIMEOUT:    tmo = data[TS_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        function void classify_sample(t_in_item it);
            int unsigned    w;
            logic [TS_W-1:0] elapsed;
            t_event         ev;
            t_out_item      res;
            w  = eff_window();
            ev = EV_NONE;
            if (it.sample) begin
                if (ones_run < MAX_WIN) ones_run++;
                zeros_run = 0;
            end else begin
                if (zeros_run < MAX_WIN) zeros_run++;
                ones_run = 0;
            end
            if (!held) begin
                if (ones_run >= w) begin
                    press_ts = it.timestamp;
                    held     = 1'b1;
                end
            end else if (zeros_run >= w) begin
                elapsed = it.timestamp - press_ts;
                if (elapsed < tmo && clicks < CLICK_MAX) clicks++;
                held = 1'b0;
            end
            // state change first, then the timer acts on the new state
            elapsed = it.timestamp - press_ts;
            if (elapsed > tmo) begin
                if (held) begin
                    if (clicks == 0) ev = EV_SINGLE_LONG;
                    else if (clicks == 1) ev = EV_DOUBLE_LONG;
                end else begin
                    if (clicks == 1) ev = EV_SINGLE;
                    else if (clicks == 2) ev = EV_DOUBLE;
                end
                clicks = '0;
            end
            res.event_res = ev;
            res.held      = held;
            pending_events.push_back(res);
        endfunction

        task report_mismatch(string msg);
            if (errors < 200) $display("%0t: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_event(t_out_item got);
            t_out_item want;
            if (pending_events.size() == 0) begin
                report_mismatch("result with no pending expectation");
                return;
            end
            want = pending_events.pop_front();
            if (got.event_res !== want.event_res)
                report_mismatch($sformatf("event_res got %0d want %0d",
                                          got.event_res, want.event_res));
            if (got.held !== want.held)
                report_mismatch($sformatf("held got %0b want %0b", got.held, want.held));
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_WINDOW_LEN;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;

    click_scoreboard sb;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int unsigned     items_sent     = 0;
    logic [TS_W-1:0] cur_ts         = '0;

    button_click_classifier #(
        .MAX_WINDOW(MAX_WIN)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // inputs change only at rising edges, so the falling edge sees the transfer to come
    always @(negedge clk) begin
        if (rst_n && in_valid && in_ready) sb.classify_sample(in_item);
        if (rst_n && out_valid && out_ready) sb.check_event(out_item);
    end

    task automatic send_item(input t_in_item it);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    task automatic send_sample(input bit s, input longint unsigned dt_lim);
        t_in_item it;
        if (dt_lim > 64'hFFFF_FFFF) dt_lim = 64'hFFFF_FFFF;
        cur_ts       = cur_ts + $urandom_range(0, dt_lim[31:0]);
        it.sample    = s;
        it.timestamp = cur_ts;
        send_item(it);
        items_sent++;
    endtask

    task automatic send_at(input bit s, input logic [TS_W-1:0] ts);
        cur_ts = ts;
        send_sample(s, 0);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic [WIN_W-1:0] w, input logic [TS_W-1:0] to,
                             input int unsigned n, input int s_pct, input int r_pct);
        int unsigned     ew;
        int unsigned     first;
        int unsigned     kind;
        bit              long_hold;
        longint unsigned stp;
        write_cfg(CFG_WINDOW_LEN, ($urandom() & 32'hFFFF_FF00) | w);
        write_cfg(CFG_TIMEOUT, to);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        ew     = sb.eff_window();
        stp    = to;
        stp    = stp / (2 * (ew + 2)) + 1;
        cur_ts = $urandom();
        first  = items_sent;
        while (items_sent - first < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                // press and release, sometimes with bounce ahead and a long hold
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 4)) send_sample($urandom_range(0, 1), stp);
                long_hold = ($urandom_range(0, 3) == 0);
                repeat (ew + $urandom_range(0, 3)) send_sample(1'b1, long_hold ? stp * 4 : stp);
                repeat (ew + $urandom_range(0, 3)) send_sample(1'b0, stp);
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 10)) send_sample($urandom_range(0, 1), stp * 2);
            end else if (kind < 95) begin
                repeat ($urandom_range(1, ew + 4)) send_sample(1'b0, stp * 4);
            end else begin
                // time jumps, backwards included
                if ($urandom_range(0, 1)) cur_ts = $urandom();
                else cur_ts = cur_ts - $urandom_range(0, stp[31:0]);
                send_sample($urandom_range(0, 1), 0);
            end
        end
        drain();
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_at(1'b0, 32'd501);
        send_at(1'b1, 32'hFFFF_FFFF);
        drain();
        write_cfg(CFG_WINDOW_LEN, 32'hFFFF_FF00);
        write_cfg(CFG_TIMEOUT, 32'd10);
        send_at(1'b1, 32'd1000);
        send_at(1'b0, 32'd1012);
        send_at(1'b1, 32'd1020);
        send_at(1'b0, 32'd1025);
        send_at(1'b0, 32'd1030);
        send_at(1'b0, 32'd1031);
        send_at(1'b1, 32'd1040);
        send_at(1'b0, 32'd1041);
        send_at(1'b1, 32'd1042);
        send_at(1'b0, 32'd1043);
        send_at(1'b0, 32'd1060);
        send_at(1'b1, 32'd1070);
        send_at(1'b0, 32'd1071);
        send_at(1'b1, 32'd1072);
        send_at(1'b1, 32'd1090);
        send_at(1'b1, 32'd1091);
        send_at(1'b1, 32'd1100);
        send_at(1'b0, 32'd1110);
        send_at(1'b1, 32'd2000);
        send_at(1'b0, 32'd2001);
        send_at(1'b1, 32'd2002);
        send_at(1'b0, 32'd2003);
        send_at(1'b1, 32'd2004);
        send_at(1'b0, 32'd2005);
        send_at(1'b1, 32'd2006);
        send_at(1'b0, 32'd2007);
        send_at(1'b0, 32'd100);
        drain();

        run_phase(8'd1,   32'd20,        250, 0,  0);
        run_phase(8'd3,   32'd60,        250, 82, 0);
        run_phase(8'd2,   32'd0,         150, 0,  82);
        run_phase(8'd5,   32'd200,       250, 38, 38);
        run_phase(8'd255, 32'hFFFF_FFFF, 200, 0,  0);
        run_phase(8'd128, 32'd2000,      200, 38, 38);
        run_phase(8'd4,   32'd1,         150, 0,  82);
        run_phase(8'd7,   32'd100,       250, 82, 0);

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

### sim.f
design/bcc_pkg.sv
design/button_click_classifier.sv
sim/tb_button_click_classifier.sv
